// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the pulse capture RTL.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PCSG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PCSG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/pcsg_pkg.sv
// Shared types, constants and codes for the pulse capture storm guard.
// No dependencies; imported by pcsg_ctrl, pcsg_dp and the top level (pcsg_ram does not use it).
`default_nettype none

package pcsg_pkg;

  localparam int unsigned RING_DEPTH       = 64;
  localparam int unsigned CYCLES_PER_MICRO = 100;

  localparam int unsigned RING_IDX_W = $clog2(RING_DEPTH);
  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned BURST_W    = 16;
  localparam int unsigned WINDOW_W   = 20;
  localparam int unsigned COOL_W     = 27;
  localparam int unsigned CFG_W      = 27;

  // Reciprocal for the divide by CYCLES_PER_MICRO: q = (x * M) >> S, exact for 32-bit x.
  localparam int unsigned DIV_SHIFT  = 32 + $clog2(CYCLES_PER_MICRO);
  localparam int unsigned MAGIC_W    = 33;
  localparam logic [63:0] DIV_MAGIC_FULL =
    ((64'd1 << DIV_SHIFT) + 64'(CYCLES_PER_MICRO) - 64'd1) / 64'(CYCLES_PER_MICRO);
  localparam logic [MAGIC_W-1:0] DIV_MAGIC = DIV_MAGIC_FULL[MAGIC_W-1:0];
  localparam int unsigned PROD_W     = DIV_SHIFT + STAMP_W;

  localparam logic                RST_ENABLE   = 1'b1;
  localparam logic [BURST_W-1:0]  RST_BURST    = 16'd200;
  localparam logic [WINDOW_W-1:0] RST_WINDOW   = 20'd10000;
  localparam logic [COOL_W-1:0]   RST_COOLDOWN = 27'd1000000;

  typedef enum logic {
    CMD_EDGE   = 1'b0,
    CMD_UPDATE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_ENABLE   = 2'd0,
    CFG_BURST    = 2'd1,
    CFG_WINDOW   = 2'd2,
    CFG_COOLDOWN = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_MUL,
    ST_EDGE_WR,
    ST_UPD_ARM,
    ST_DR_RD,
    ST_DR_DAT
  } state_t;

  typedef struct packed {
    logic edge_start;
    logic edge_mul;
    logic edge_commit;
    logic upd_start;
    logic arm;
    logic rd_issue;
    logic word_take;
  } ctrl_t;

  typedef struct packed {
    logic masked;
    logic enable;
    logic ring_empty;
    logic holding;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/pcsg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pcsg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pcsg_ctrl.sv
// Sequencer for edge capture, re-arm and ring drain.
// Depends on pcsg_pkg and assert_macros.svh; drives pcsg_dp through ctrl_t.
`default_nettype none
`include "assert_macros.svh"

module pcsg_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_cmd,
  output      logic            in_stall,
  input  wire pcsg_pkg::stat_t sts,
  output      pcsg_pkg::ctrl_t cmd
);

  import pcsg_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          // masked edges and disabled updates leave everything untouched
          if (in_cmd == CMD_EDGE) begin
            if (!sts.masked) begin
              cmd.edge_start = 1'b1;
              state_nxt      = ST_EDGE_MUL;
            end
          end else if (sts.enable) begin
            cmd.upd_start = 1'b1;
            state_nxt     = ST_UPD_ARM;
          end
        end
      end
      ST_EDGE_MUL: begin
        cmd.edge_mul = 1'b1;
        state_nxt    = ST_EDGE_WR;
      end
      ST_EDGE_WR: begin
        cmd.edge_commit = 1'b1;
        state_nxt       = ST_IDLE;
      end
      ST_UPD_ARM: begin
        cmd.arm   = 1'b1;
        state_nxt = ST_DR_RD;
      end
      ST_DR_RD: begin
        if (sts.ring_empty) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.rd_issue = 1'b1;
          state_nxt    = ST_DR_DAT;
        end
      end
      ST_DR_DAT: begin
        // a completed pair must wait for a free output register
        if (!sts.holding || sts.out_free) begin
          cmd.word_take = 1'b1;
          state_nxt     = ST_DR_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `PCSG_ASSERT_NXT(a_pair_waits,
    state_r == ST_DR_DAT && sts.holding && !sts.out_free,
    state_r == ST_DR_DAT,
    "drain moved on while a pair had nowhere to go")
  `PCSG_ASSERT_IMP(a_read_not_empty,
    cmd.rd_issue,
    !sts.ring_empty,
    "ring read issued with the ring empty")

endmodule

`default_nettype wire

// File: hw/rtl/pcsg_dp.sv
// Datapath: configuration, edge timing, storm guard, width ring and output register.
// Depends on pcsg_pkg, pcsg_ram and assert_macros.svh; steered by pcsg_ctrl.
`default_nettype none
`include "assert_macros.svh"

module pcsg_dp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [pcsg_pkg::CFG_W-1:0]   cfg_wdata,
  input  wire logic [pcsg_pkg::STAMP_W-1:0] in_stamp_cycles,
  input  wire logic [pcsg_pkg::STAMP_W-1:0] in_now_us,
  input  wire pcsg_pkg::ctrl_t              cmd,
  output      pcsg_pkg::stat_t              sts,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      logic [pcsg_pkg::STAMP_W-1:0] out_width_first,
  output      logic [pcsg_pkg::STAMP_W-1:0] out_width_second,
  output      logic                         out_last
);

  import pcsg_pkg::*;

  // configuration
  logic                enable_r;
  logic [BURST_W-1:0]  burst_limit_r;
  logic [WINDOW_W-1:0] window_us_r;
  logic [COOL_W-1:0]   cooldown_us_r;
  logic [STAMP_W-1:0]  window_cyc_r;

  // item and guard state
  logic [STAMP_W-1:0]    stamp_r;
  logic [STAMP_W-1:0]    now_r;
  logic [STAMP_W-1:0]    diff_r;
  logic [PROD_W-1:0]     prod_r;
  logic [STAMP_W-1:0]    prev_edge_r;
  logic [RING_IDX_W-1:0] head_r;
  logic [RING_IDX_W-1:0] tail_r;
  logic [BURST_W-1:0]    burst_cnt_r;
  logic [STAMP_W-1:0]    burst_start_r;
  logic                  masked_r;
  logic [STAMP_W-1:0]    deadline_r;
  logic [STAMP_W-1:0]    held_r;
  logic                  holding_r;
  logic                  out_valid_r;
  logic [STAMP_W-1:0]    out_first_r;
  logic [STAMP_W-1:0]    out_second_r;
  logic                  out_last_r;

  logic [RING_IDX_W-1:0] head_inc;
  logic [RING_IDX_W-1:0] tail_inc;
  logic                  ring_full;
  logic [RING_IDX_W:0]   remain;
  logic [STAMP_W-1:0]    width_us;
  logic [BURST_W-1:0]    burst_inc;
  logic [STAMP_W-1:0]    burst_span;
  logic [STAMP_W-1:0]    dl_sum;
  logic [STAMP_W-1:0]    since_dl;
  logic [STAMP_W-1:0]    ring_rdata;
  logic                  out_take;
  logic                  ring_we;

  assign head_inc  = (head_r == RING_IDX_W'(RING_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc  = (tail_r == RING_IDX_W'(RING_DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign ring_full = (head_inc == tail_r);
  assign remain    = (head_r >= tail_r)
                   ? {1'b0, head_r} - {1'b0, tail_r}
                   : {1'b0, head_r} + (RING_IDX_W+1)'(RING_DEPTH) - {1'b0, tail_r};
  assign width_us  = prod_r[DIV_SHIFT +: STAMP_W];
  assign burst_inc = burst_cnt_r + 1'b1;
  assign burst_span = stamp_r - burst_start_r;
  assign dl_sum    = now_r + STAMP_W'(cooldown_us_r);
  assign since_dl  = now_r - deadline_r;
  assign out_take  = out_valid_r && !out_stall;
  assign ring_we   = cmd.edge_commit && !ring_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r      <= RST_ENABLE;
      burst_limit_r <= RST_BURST;
      window_us_r   <= RST_WINDOW;
      cooldown_us_r <= RST_COOLDOWN;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ENABLE:   enable_r      <= cfg_wdata[0];
        CFG_BURST:    burst_limit_r <= cfg_wdata[BURST_W-1:0];
        CFG_WINDOW:   window_us_r   <= cfg_wdata[WINDOW_W-1:0];
        CFG_COOLDOWN: cooldown_us_r <= cfg_wdata[COOL_W-1:0];
        default: ;
      endcase
    end
  end

  // window in cycles, registered from window_us_r, so a storm check just after a window write sees the old window
  always_ff @(posedge clk) begin
    window_cyc_r <= STAMP_W'(window_us_r) * STAMP_W'(CYCLES_PER_MICRO);
  end

  // item latches and product: payload only
  always_ff @(posedge clk) begin
    if (cmd.edge_start || cmd.upd_start) begin
      stamp_r <= in_stamp_cycles;
      now_r   <= in_now_us;
    end
    if (cmd.edge_start) begin
      diff_r <= in_stamp_cycles - prev_edge_r;
    end
    if (cmd.edge_mul) begin
      prod_r <= PROD_W'(diff_r) * PROD_W'(DIV_MAGIC);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_edge_r   <= '0;
      head_r        <= '0;
      tail_r        <= '0;
      burst_cnt_r   <= '0;
      burst_start_r <= '0;
      masked_r      <= 1'b0;
      deadline_r    <= '0;
      held_r        <= '0;
      holding_r     <= 1'b0;
    end else begin
      if (cmd.edge_start) begin
        prev_edge_r <= in_stamp_cycles;
      end
      if (cmd.edge_commit) begin
        if (!ring_full) begin
          head_r <= head_inc;
        end
        if (burst_inc >= burst_limit_r) begin
          if (burst_span < window_cyc_r) begin
            masked_r   <= 1'b1;
            deadline_r <= '0;
          end
          burst_cnt_r   <= '0;
          burst_start_r <= stamp_r;
        end else begin
          burst_cnt_r <= burst_inc;
        end
      end
      if (cmd.arm && masked_r) begin
        if (deadline_r == '0) begin
          // zero means unset, so nudge a zero deadline to one
          deadline_r <= (dl_sum == '0) ? STAMP_W'(1) : dl_sum;
        end else if (!since_dl[STAMP_W-1]) begin
          burst_cnt_r   <= '0;
          burst_start_r <= stamp_r;
          deadline_r    <= '0;
          masked_r      <= 1'b0;
        end
      end
      if (cmd.rd_issue) begin
        tail_r <= tail_inc;
      end
      if (cmd.word_take) begin
        if (!holding_r) begin
          held_r    <= ring_rdata;
          holding_r <= 1'b1;
        end else begin
          holding_r <= 1'b0;
        end
      end
    end
  end

  // output register: a new pair may load as the old beat leaves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.word_take && holding_r) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.word_take && holding_r) begin
      out_first_r  <= held_r;
      out_second_r <= ring_rdata;
      out_last_r   <= (remain < (RING_IDX_W+1)'(2));
    end
  end

  pcsg_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (head_r),
    .wdata (width_us),
    .re    (cmd.rd_issue),
    .raddr (tail_r),
    .rdata (ring_rdata)
  );

  assign sts.masked     = masked_r;
  assign sts.enable     = enable_r;
  assign sts.ring_empty = (head_r == tail_r);
  assign sts.holding    = holding_r;
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid        = out_valid_r;
  assign out_width_first  = out_first_r;
  assign out_width_second = out_second_r;
  assign out_last         = out_last_r;

  `PCSG_ASSERT_IMP(a_pair_lands_free,
    cmd.word_take && holding_r,
    !out_valid_r || !out_stall,
    "pair loaded over an unaccepted beat")
  `PCSG_ASSERT_NXT(a_full_ring_holds,
    cmd.edge_commit && ring_full,
    head_r == $past(head_r),
    "ring head advanced into the tail")

endmodule

`default_nettype wire

// File: hw/rtl/pulse_capture_storm_guard_top.sv
// Edge item: accept, reciprocal multiply for the divide, then ring write and storm check;
// a masked edge is accepted and dropped. Update item (dropped while disabled): accept, re-arm,
// then for each ring word drained a RAM read then use, waiting while a finished pair meets out_stall.
// One item in flight; the output register lets the next item in while a beat waits.
// Reset (rst_n low, synchronous) clears control state and loads register defaults;
// the width ring RAM is not cleared and needs no clearing pass.
`default_nettype none

module pulse_capture_storm_guard_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [pcsg_pkg::CFG_W-1:0]   cfg_wdata,
  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire logic                         in_cmd,
  input  wire logic [pcsg_pkg::STAMP_W-1:0] in_stamp_cycles,
  input  wire logic [pcsg_pkg::STAMP_W-1:0] in_now_us,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      logic [pcsg_pkg::STAMP_W-1:0] out_width_first,
  output      logic [pcsg_pkg::STAMP_W-1:0] out_width_second,
  output      logic                         out_last
);

  import pcsg_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  pcsg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .sts      (stat),
    .cmd      (ctrl)
  );

  pcsg_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_stamp_cycles  (in_stamp_cycles),
    .in_now_us        (in_now_us),
    .cmd              (ctrl),
    .sts              (stat),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_width_first  (out_width_first),
    .out_width_second (out_width_second),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire
